FILE: design/lrtf_pkg.sv
// Shared types and constants for the longest-remaining-time-first scheduler.
`default_nettype none
package lrtf_pkg;

  localparam int unsigned MAX_JOBS  = 16;
  localparam int unsigned SLOT_W    = $clog2(MAX_JOBS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_JOBS - 1);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_RAN   = 2'd2,
    ST_IDLE  = 2'd3
  } status_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  job_id;
    logic [15:0] burst;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  run_id;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  job_id;
    logic [15:0] burst;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_stat_t;

endpackage
`default_nettype wire

FILE: design/longest_remaining_time_first_scheduler_core.sv
// An add item passes through the command queue and is answered from the result register.
// A tick item scans every table slot in turn and then commits; the engine takes no other
// item until that commit is done. Adds are taken one per cycle while out_stall_i is low.
// A two-entry command queue keeps taking items while the engine scans or a result waits.
// Reset (rst_ni low, asynchronous) empties the queue, the job table and the result
// register and clears time and the running job.
// Top level of the longest-remaining-time-first scheduler.
`default_nettype none
module longest_remaining_time_first_scheduler_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire lrtf_pkg::in_t   in_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output lrtf_pkg::out_t       out_o
);

  lrtf_pkg::cmd_stat_t cmd;
  logic                pop;

  lrtf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .cmd_o      (cmd),
    .pop_i      (pop)
  );

  lrtf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

FILE: design/lrtf_front.sv
// Front end: accepts items, decodes the action and queues commands for the engine.
`default_nettype none
module lrtf_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lrtf_pkg::in_t        in_i,
  output lrtf_pkg::cmd_stat_t       cmd_o,
  input  wire logic                 pop_i
);

  lrtf_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;
  logic [1:0]     cnt_d;
  logic           push;
  logic           pop;
  lrtf_pkg::cmd_t new_cmd;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    new_cmd.op     = in_i.action ? lrtf_pkg::OP_TICK : lrtf_pkg::OP_ADD;
    new_cmd.job_id = in_i.job_id;
    new_cmd.burst  = in_i.burst;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cmd   = entry_q[rd_ptr_q];

endmodule
`default_nettype wire

FILE: design/lrtf_engine.sv
// Back end: job table, slot scan, tick commit and result register.
`default_nettype none
module lrtf_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lrtf_pkg::cmd_stat_t  cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lrtf_pkg::out_t            out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  localparam int unsigned SW = lrtf_pkg::SLOT_W;

  // job table payload
  logic [7:0]  id_q   [lrtf_pkg::MAX_JOBS];
  logic [31:0] arr_q  [lrtf_pkg::MAX_JOBS];
  logic [15:0] bur_q  [lrtf_pkg::MAX_JOBS];
  logic [15:0] rem_q  [lrtf_pkg::MAX_JOBS];
  logic [lrtf_pkg::MAX_JOBS-1:0] valid_q;

  state_e         state_q;
  logic [SW-1:0]  scan_idx_q;
  logic [31:0]    time_q;
  logic [SW-1:0]  running_slot_q;
  logic           running_valid_q;
  logic           have_best_q;
  logic [SW-1:0]  best_idx_q;
  logic [15:0]    best_rem_q;
  logic [31:0]    best_arr_q;
  logic           run_ok_q;
  logic [15:0]    run_rem_q;
  logic           out_valid_q;
  lrtf_pkg::out_t out_q;

  logic           out_free;
  logic [SW-1:0]  rd_idx;
  logic           rd_v;
  logic [7:0]     rd_id;
  logic [31:0]    rd_arr;
  logic [15:0]    rd_bur;
  logic [15:0]    rd_rem;
  logic           cand_better;
  logic           run_keep;
  logic [SW-1:0]  pick_idx;
  logic [31:0]    time_next;
  logic [31:0]    tat;
  logic [31:0]    wt;
  logic           finish;
  logic           free_found;
  logic [SW-1:0]  free_idx;
  logic           add_go;
  logic           commit_go;
  lrtf_pkg::out_t add_res;
  lrtf_pkg::out_t tick_res;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign run_keep  = run_ok_q && !(best_rem_q > run_rem_q);
  assign pick_idx  = run_keep ? running_slot_q : best_idx_q;
  assign rd_idx    = (state_q == S_COMMIT) ? pick_idx : scan_idx_q;
  assign rd_v      = valid_q[rd_idx];
  assign rd_id     = id_q[rd_idx];
  assign rd_arr    = arr_q[rd_idx];
  assign rd_bur    = bur_q[rd_idx];
  assign rd_rem    = rem_q[rd_idx];
  assign time_next = time_q + 32'd1;
  assign tat       = time_next - rd_arr;
  assign wt        = tat - {16'd0, rd_bur};
  assign finish    = (rd_rem <= 16'd1);

  // strict compares keep the earlier slot on a full tie
  assign cand_better = rd_v && (!have_best_q || (rd_rem > best_rem_q) ||
                       ((rd_rem == best_rem_q) && (rd_arr < best_arr_q)));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = lrtf_pkg::MAX_JOBS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign add_go    = (state_q == S_IDLE) && cmd_i.valid &&
                     (cmd_i.cmd.op == lrtf_pkg::OP_ADD) && out_free;
  assign pop_o     = (state_q == S_IDLE) && cmd_i.valid &&
                     ((cmd_i.cmd.op == lrtf_pkg::OP_TICK) || out_free);
  assign commit_go = (state_q == S_COMMIT) && out_free;

  always_comb begin
    add_res        = '0;
    add_res.status = free_found ? lrtf_pkg::ST_ADDED : lrtf_pkg::ST_FULL;
  end

  always_comb begin
    tick_res = '0;
    if (!have_best_q) begin
      tick_res.status = lrtf_pkg::ST_IDLE;
    end else begin
      tick_res.status = lrtf_pkg::ST_RAN;
      tick_res.run_id = rd_id;
      if (finish) begin
        tick_res.finished        = 1'b1;
        tick_res.completion_time = time_next;
        tick_res.turnaround      = tat;
        tick_res.waiting         = wt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      scan_idx_q      <= '0;
      time_q          <= 32'd0;
      running_slot_q  <= '0;
      running_valid_q <= 1'b0;
      have_best_q     <= 1'b0;
      best_idx_q      <= '0;
      best_rem_q      <= 16'd0;
      best_arr_q      <= 32'd0;
      run_ok_q        <= 1'b0;
      run_rem_q       <= 16'd0;
      valid_q         <= '0;
      out_valid_q     <= 1'b0;
      out_q           <= '0;
    end else begin
      if (add_go || commit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (add_go) begin
            out_q <= add_res;
            if (free_found) begin
              valid_q[free_idx] <= 1'b1;
            end
          end else if (pop_o) begin
            scan_idx_q  <= '0;
            have_best_q <= 1'b0;
            run_ok_q    <= 1'b0;
            state_q     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cand_better) begin
            have_best_q <= 1'b1;
            best_idx_q  <= scan_idx_q;
            best_rem_q  <= rd_rem;
            best_arr_q  <= rd_arr;
          end
          if (scan_idx_q == running_slot_q) begin
            run_ok_q  <= running_valid_q && rd_v;
            run_rem_q <= rd_rem;
          end
          if (scan_idx_q == lrtf_pkg::LAST_SLOT) begin
            state_q <= S_COMMIT;
          end else begin
            scan_idx_q <= scan_idx_q + SW'(1);
          end
        end
        S_COMMIT: begin
          if (commit_go) begin
            time_q  <= time_next;
            out_q   <= tick_res;
            state_q <= S_IDLE;
            if (!have_best_q) begin
              running_valid_q <= 1'b0;
            end else if (finish) begin
              valid_q[pick_idx] <= 1'b0;
              running_valid_q   <= 1'b0;
              running_slot_q    <= '0;
            end else begin
              running_valid_q <= 1'b1;
              running_slot_q  <= pick_idx;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_go && free_found) begin
      id_q[free_idx]  <= cmd_i.cmd.job_id;
      arr_q[free_idx] <= time_q;
      bur_q[free_idx] <= cmd_i.cmd.burst;
      rem_q[free_idx] <= cmd_i.cmd.burst;
    end else if (commit_go && have_best_q && !finish) begin
      rem_q[pick_idx] <= rd_rem - 16'd1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_running_slot_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_valid_q |-> valid_q[running_slot_q])
    else $error("running slot is not occupied");

  a_pick_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && have_best_q) |-> valid_q[pick_idx])
    else $error("picked slot is not occupied");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_idx_q != lrtf_pkg::LAST_SLOT) |=>
      (state_q == S_SCAN && scan_idx_q == $past(scan_idx_q) + SW'(1)))
    else $error("slot scan skipped or stopped");

  a_time_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_go |=> $stable(time_q))
    else $error("time moved outside a tick commit");
`endif

endmodule
`default_nettype wire
